### hdl/shf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package shf_pkg;

    localparam int MAX_ROW_WIDTH = 4096;
    localparam int PIXEL_BITS    = 16;
    localparam int LEN_W         = $clog2(MAX_ROW_WIDTH + 1);
    localparam int RQ_DEPTH      = 4;
    localparam int RQ_PTR_W      = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W      = $clog2(RQ_DEPTH + 1);

    typedef enum logic [0:0] {
        CFG_FILL_MODE    = 1'b0,
        CFG_INVALID_CODE = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel_value;
        logic                  row_end;
    } t_in_item;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] fill_value;
        logic [LEN_W-1:0]      run_length;
        logic                  row_done;
    } t_out_item;

    // up to two runs per pixel, first slot always used first
    typedef struct packed {
        logic [1:0] vld;
        t_out_item  r0;
        t_out_item  r1;
    } t_res_pair;

    function automatic logic [LEN_W-1:0] cap_len(input logic [LEN_W:0] n);
        logic [LEN_W:0] lim;
        lim = (LEN_W + 1)'(MAX_ROW_WIDTH);
        cap_len = (n > lim) ? lim[LEN_W-1:0] : n[LEN_W-1:0];
    endfunction

endpackage

`default_nettype wire

### hdl/shf_proc.sv
`timescale 1ns / 1ps
`default_nettype none

module shf_proc import shf_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_adv,
    input  wire t_in_item              i_item,
    input  wire logic                  i_fill_mode,
    input  wire logic [PIXEL_BITS-1:0] i_invalid_code,
    output t_res_pair                  o_res
);

    logic [PIXEL_BITS-1:0] r_left_value, n_left_value;
    logic                  r_left_known, n_left_known;
    logic [LEN_W-1:0]      r_hole_count, n_hole_count;
    logic                  r_phase, n_phase;
    logic                  r_lead, n_lead;

    logic [PIXEL_BITS-1:0] v;
    logic [PIXEL_BITS-1:0] empty_code;
    logic [PIXEL_BITS-1:0] fill;
    logic                  is_hole;
    logic [LEN_W:0]        hc_ext;
    logic [LEN_W:0]        lead_ext;

    assign v          = i_item.pixel_value;
    assign empty_code = i_fill_mode ? '0 : '1;
    assign is_hole    = i_fill_mode ? (v == i_invalid_code) : (v <= i_invalid_code);
    assign hc_ext     = {1'b0, r_hole_count};
    assign lead_ext   = (LEN_W + 1)'(r_lead);

    always_comb begin
        if (!r_left_known) begin
            fill = v;
        end else if (i_fill_mode) begin
            fill = (r_left_value > v) ? r_left_value : v;
        end else begin
            fill = (r_left_value < v) ? r_left_value : v;
        end
    end

    always_comb begin
        n_left_value = r_left_value;
        n_left_known = r_left_known;
        n_hole_count = r_hole_count;
        n_phase      = r_phase;
        n_lead       = r_lead;
        o_res        = '0;

        if (i_item.row_end) begin
            o_res.vld           = 2'b01;
            o_res.r0.fill_value = r_left_known ? r_left_value : empty_code;
            o_res.r0.run_length = cap_len(hc_ext + lead_ext + (LEN_W + 1)'(1));
            o_res.r0.row_done   = 1'b1;
            n_left_value = '0;
            n_left_known = 1'b0;
            n_hole_count = '0;
            n_phase      = 1'b0;
            n_lead       = 1'b0;
        end else if (!r_phase) begin
            n_lead  = 1'b1;
            n_phase = 1'b1;
        end else if (is_hole) begin
            if (r_hole_count != LEN_W'(MAX_ROW_WIDTH)) begin
                n_hole_count = r_hole_count + LEN_W'(1);
            end
        end else begin
            if (r_hole_count != '0) begin
                // pending hole run goes out ahead of the pixel itself
                o_res.vld           = 2'b11;
                o_res.r0.fill_value = fill;
                o_res.r0.run_length = cap_len(hc_ext + lead_ext);
                o_res.r1.fill_value = v;
                o_res.r1.run_length = LEN_W'(1);
            end else begin
                o_res.vld           = 2'b01;
                o_res.r0.fill_value = v;
                o_res.r0.run_length = cap_len(lead_ext + (LEN_W + 1)'(1));
            end
            n_lead       = 1'b0;
            n_hole_count = '0;
            n_left_value = v;
            n_left_known = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_value <= '0;
            r_left_known <= 1'b0;
            r_hole_count <= '0;
            r_phase      <= 1'b0;
            r_lead       <= 1'b0;
        end else if (i_adv) begin
            r_left_value <= n_left_value;
            r_left_known <= n_left_known;
            r_hole_count <= n_hole_count;
            r_phase      <= n_phase;
            r_lead       <= n_lead;
        end
    end

endmodule

`default_nettype wire

### hdl/shf_rq.sv
`timescale 1ns / 1ps
`default_nettype none

module shf_rq import shf_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_res_pair i_res,
    output logic           o_space,
    output logic           o_valid,
    output t_out_item      o_data,
    input  wire logic      i_ready
);

    t_out_item            r_mem [RQ_DEPTH];
    logic [RQ_PTR_W-1:0]  r_wp, n_wp;
    logic [RQ_PTR_W-1:0]  r_rp, n_rp;
    logic [RQ_CNT_W-1:0]  r_cnt, n_cnt;
    logic                 pop;
    logic [1:0]           n_push;
    logic [RQ_PTR_W-1:0]  wp1;

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign pop     = o_valid && i_ready;
    // room for the worst case of two runs from one pixel
    assign o_space = (r_cnt <= RQ_CNT_W'(RQ_DEPTH - 2));
    assign n_push  = i_push ? (2'(i_res.vld[0]) + 2'(i_res.vld[1])) : 2'd0;
    assign wp1     = r_wp + RQ_PTR_W'(1);

    always_comb begin
        n_wp  = r_wp + RQ_PTR_W'(n_push);
        n_rp  = r_rp + RQ_PTR_W'(pop);
        n_cnt = r_cnt + RQ_CNT_W'(n_push) - RQ_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push && i_res.vld[0]) begin
            r_mem[r_wp] <= i_res.r0;
        end
        if (i_push && i_res.vld[1]) begin
            r_mem[wp1] <= i_res.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

### hdl/scanline_hole_fill_core.sv
`timescale 1ns / 1ps
`default_nettype none

// channel | direction | handshake                      | payload
// in      | in        | i_in_valid / o_in_ready        | i_in_data  (t_in_item)
// out     | out       | o_out_valid / i_out_ready      | o_out_data (t_out_item)
// cfg     | in        | i_cfg_valid / o_cfg_ready      | i_cfg_index, i_cfg_data
//
// One pixel per cycle while the queue has room: input register, then hole logic
// into a 4-entry run queue, which registers each run before it reaches the output.
// A pixel that closes a hole emits two runs; the queue's single read port
// drains one run per cycle when the sink is ready, so sustained rate is 1 pixel/cycle
// less those extra runs. Input stalls only when the queue lacks room for two runs.
// Synchronous active-low reset clears row state, queue and config registers.

module scanline_hole_fill_core import shf_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_item              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_data,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire t_cfg_index            i_cfg_index,
    input  wire logic [PIXEL_BITS-1:0] i_cfg_data
);

    logic                  r_fill_mode;
    logic [PIXEL_BITS-1:0] r_invalid_code;
    logic                  r_in_vld;
    t_in_item              r_in;
    logic                  space;
    logic                  adv;
    t_res_pair             res;

    // a held pixel is still processed under the settings it arrived with
    assign o_cfg_ready = !r_in_vld;
    assign adv         = r_in_vld && space;
    assign o_in_ready  = !r_in_vld || space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_mode    <= 1'b0;
            r_invalid_code <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_FILL_MODE:    r_fill_mode    <= i_cfg_data[0];
                CFG_INVALID_CODE: r_invalid_code <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    shf_proc u_proc (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (adv),
        .i_item         (r_in),
        .i_fill_mode    (r_fill_mode),
        .i_invalid_code (r_invalid_code),
        .o_res          (res)
    );

    shf_rq u_rq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (adv),
        .i_res   (res),
        .o_space (space),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_ready (i_out_ready)
    );

endmodule

`default_nettype wire

### tb/sv/tb_scanline_hole_fill_core.sv
`timescale 1ns / 1ps

module tb_scanline_hole_fill_core import shf_pkg::*; ();

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 10;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_PIXELS   = 50;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    t_cfg_index            i_cfg_index = CFG_FILL_MODE;
    logic [PIXEL_BITS-1:0] i_cfg_data  = '0;

    scanline_hole_fill_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    t_in_item  pixel_queue[$];
    t_out_item expected_runs[$];

    // predicted block state
    bit                    fill_max   = 1'b0;
    logic [PIXEL_BITS-1:0] hole_code  = '0;
    logic [PIXEL_BITS-1:0] left_px    = '0;
    bit                    left_seen  = 1'b0;
    int                    pend_holes = 0;
    int                    lead_owed  = 0;
    bit                    in_row     = 1'b0;

    int in_gap       = 0;
    int out_hold     = 0;
    int out_draw     = 0;
    bit in_idle_on   = 1'b0;
    bit out_idle_on  = 1'b0;
    int mismatches   = 0;
    int pixels_sent  = 0;
    int runs_seen    = 0;
    int rows_closed  = 0;
    int reg_writes   = 0;
    int quiet_cycles = 0;
    t_out_item want;

    task automatic push_run(input logic [PIXEL_BITS-1:0] value, input int n, input bit done);
        t_out_item r;
        r.fill_value = value;
        r.run_length = (n > MAX_ROW_WIDTH) ? LEN_W'(MAX_ROW_WIDTH) : LEN_W'(n);
        r.row_done   = done;
        expected_runs.push_back(r);
    endtask

    task automatic predict_pixel(input t_in_item px);
        logic [PIXEL_BITS-1:0] v;
        logic [PIXEL_BITS-1:0] f;
        bit                    is_hole;
        v = px.pixel_value;
        if (px.row_end) begin
            // empty interior: all ones for min fill, zero for max fill
            f = left_seen ? left_px : (fill_max ? '0 : '1);
            push_run(f, pend_holes + 1 + lead_owed, 1'b1);
            rows_closed++;
            left_px    = '0;
            left_seen  = 1'b0;
            pend_holes = 0;
            lead_owed  = 0;
            in_row     = 1'b0;
            return;
        end
        if (!in_row) begin
            // first pixel is dropped; it rides on the first run of the row
            lead_owed = 1;
            in_row    = 1'b1;
            return;
        end
        is_hole = fill_max ? (v == hole_code) : (v <= hole_code);
        if (is_hole) begin
            pend_holes = (pend_holes >= MAX_ROW_WIDTH) ? MAX_ROW_WIDTH : pend_holes + 1;
            return;
        end
        if (pend_holes > 0) begin
            f = v;
            if (left_seen)
                f = fill_max ? ((left_px > v) ? left_px : v) : ((left_px < v) ? left_px : v);
            push_run(f, pend_holes + lead_owed, 1'b0);
            lead_owed  = 0;
            pend_holes = 0;
        end
        push_run(v, 1 + lead_owed, 1'b0);
        lead_owed = 0;
        left_px   = v;
        left_seen = 1'b1;
    endtask

    // pixel driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap     <= 0;
        end else if (!i_in_valid || o_in_ready) begin
            if (in_gap > 0) begin
                in_gap     <= in_gap - 1;
                i_in_valid <= 1'b0;
            end else if (pixel_queue.size() != 0) begin
                i_in_data  <= pixel_queue.pop_front();
                i_in_valid <= 1'b1;
                in_gap     <= in_idle_on ? $urandom_range(0, 11) : 0;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // run sink with random back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_hold    <= 0;
        end else if (out_hold > 0) begin
            out_hold    <= out_hold - 1;
            i_out_ready <= (out_hold == 1);
        end else if (o_out_valid && i_out_ready && out_idle_on) begin
            out_draw     = $urandom_range(0, 11);
            out_hold    <= out_draw;
            i_out_ready <= (out_draw == 0);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // monitor: register writes, pixel requests and run checks
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                reg_writes++;
                if (i_cfg_index == CFG_FILL_MODE)
                    fill_max = i_cfg_data[0];
                else
                    hole_code = i_cfg_data;
            end
            if (i_in_valid && o_in_ready) begin
                pixels_sent++;
                predict_pixel(i_in_data);
            end
            if (o_out_valid && i_out_ready) begin
                runs_seen++;
                if (expected_runs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("run %0d unexpected: value %0d len %0d done %0b", runs_seen,
                                 o_out_data.fill_value, o_out_data.run_length,
                                 o_out_data.row_done);
                end else begin
                    want = expected_runs.pop_front();
                    if (o_out_data.fill_value !== want.fill_value ||
                        o_out_data.run_length !== want.run_length ||
                        o_out_data.row_done !== want.row_done) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $write("run %0d: expected value %0d len %0d done %0b, ",
                                   runs_seen, want.fill_value, want.run_length,
                                   want.row_done);
                            $display("got value %0d len %0d done %0b",
                                     o_out_data.fill_value, o_out_data.run_length,
                                     o_out_data.row_done);
                        end
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic push_pixel(input logic [PIXEL_BITS-1:0] value, input bit last);
        t_in_item px;
        px.pixel_value = value;
        px.row_end     = last;
        pixel_queue.push_back(px);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [PIXEL_BITS-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // block is idle once nothing is queued, in flight or owed
    task automatic wait_idle();
        while (pixel_queue.size() != 0 || i_in_valid || expected_runs.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [PIXEL_BITS-1:0] pick_value(input bit mode,
                                                         input logic [PIXEL_BITS-1:0] code,
                                                         input bit want_hole);
        logic [PIXEL_BITS-1:0] val;
        if ($urandom_range(0, 9) == 0)
            return PIXEL_BITS'($urandom);
        if (want_hole)
            return mode ? code : PIXEL_BITS'($urandom_range(0, int'(code)));
        if (mode) begin
            do val = PIXEL_BITS'($urandom); while (val == code);
            return val;
        end
        if (code == '1)
            return PIXEL_BITS'($urandom);
        return PIXEL_BITS'($urandom_range(int'(code) + 1, 65535));
    endfunction

    task automatic gen_row(input bit mode, input logic [PIXEL_BITS-1:0] code, input int len,
                           input int hole_pct, input bit closed);
        for (int i = 0; i < len; i++) begin
            if (i == 0)
                push_pixel(PIXEL_BITS'($urandom), closed && len == 1);
            else
                push_pixel(pick_value(mode, code, $urandom_range(1, 100) <= hole_pct),
                           closed && i == len - 1);
        end
    endtask

    initial begin
        int                    budget;
        int                    len;
        bit                    cur_mode;
        bit                    nm;
        logic [PIXEL_BITS-1:0] cur_inv;
        logic [PIXEL_BITS-1:0] ni;
        cur_mode = 1'b0;
        cur_inv  = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: min fill, only zero marks a hole
        @(negedge i_clk);
        push_pixel(16'h0000, 1'b1);
        push_pixel(16'hFFFF, 1'b0);
        push_pixel(16'h0000, 1'b1);
        push_pixel(16'h1234, 1'b0);
        push_pixel(16'h0000, 1'b0);
        push_pixel(16'h0000, 1'b0);
        push_pixel(16'd500, 1'b0);
        push_pixel(16'h0000, 1'b0);
        push_pixel(16'd300, 1'b0);
        push_pixel(16'hFFFF, 1'b0);
        push_pixel(16'h0000, 1'b0);
        push_pixel(16'd7, 1'b1);
        wait_idle();

        cur_mode = 1'b1;
        cur_inv  = 16'h8000;
        write_reg(CFG_FILL_MODE, {15'($urandom), cur_mode});
        write_reg(CFG_INVALID_CODE, cur_inv);
        @(negedge i_clk);
        push_pixel(16'h0000, 1'b0);
        push_pixel(16'h8000, 1'b0);
        push_pixel(16'h0000, 1'b0);
        push_pixel(16'h8000, 1'b0);
        push_pixel(16'h8000, 1'b0);
        push_pixel(16'hFFFF, 1'b0);
        push_pixel(16'h8000, 1'b0);
        push_pixel(16'h8000, 1'b1);
        push_pixel(16'd5, 1'b0);
        push_pixel(16'h8000, 1'b0);
        push_pixel(16'h8000, 1'b1);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_idle();
            case (p)
                0: begin nm = 1'b0; ni = 16'hFFFF; end
                1: begin nm = 1'b1; ni = 16'h0000; end
                2: begin nm = 1'b1; ni = 16'hFFFF; end
                3: begin nm = 1'b0; ni = 16'h0000; end
                default: begin
                    nm = 1'($urandom_range(0, 1));
                    ni = $urandom_range(0, 1) ? PIXEL_BITS'($urandom)
                                              : PIXEL_BITS'($urandom_range(0, 300));
                end
            endcase
            if (nm != cur_mode || $urandom_range(0, 1))
                write_reg(CFG_FILL_MODE, {15'($urandom), nm});
            if (ni != cur_inv || $urandom_range(0, 1))
                write_reg(CFG_INVALID_CODE, ni);
            cur_mode = nm;
            cur_inv  = ni;
            @(negedge i_clk);
            in_idle_on  = (p != 0) && $urandom_range(0, 3) != 0;
            out_idle_on = (p != 0) && $urandom_range(0, 3) != 0;
            budget = 0;
            while (budget < PHASE_PIXELS) begin
                case ($urandom_range(0, 19))
                    0:          len = $urandom_range(41, 200);
                    1, 2, 3, 4: len = $urandom_range(9, 40);
                    default:    len = $urandom_range(1, 8);
                endcase
                // a row left open here is finished under the next settings
                gen_row(cur_mode, cur_inv, len, 25 * $urandom_range(0, 4),
                        budget + len < PHASE_PIXELS || $urandom_range(0, 3) != 0);
                budget += len;
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("sent %0d pixels over %0d closed rows, checked %0d runs", pixels_sent,
                 rows_closed, runs_seen);
        $display("%0d register writes across min and max fill modes, %0d mismatches",
                 reg_writes, mismatches);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
